FILE: design/rc_pulse_width_capture_macros.svh
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_macros.svh
// Assertion macros shared by the pulse width capture checker.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_WIDTH_CAPTURE_MACROS_SVH
`define RC_PULSE_WIDTH_CAPTURE_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define RCPW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define RCPW_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/rcpw_pkg.sv
// ----------------------------------------------------------------------------
// rcpw_pkg
// Types and codes shared by the pulse width capture block.
// ----------------------------------------------------------------------------
package rcpw_pkg;

    // result status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_REPORT = 2'd2;

    typedef struct packed {
        logic [7:0]  pin_levels;
        logic [15:0] timer_value;
    } sample_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  channel;
        logic [15:0] pulse_width;
        logic [15:0] min_width;
        logic [15:0] max_width;
        logic        last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic       in_release;    // held sample is consumed
        logic       start_wr;      // store timer as start of current slot
        logic       frame_end_wr;  // store timer as frame end
        logic       rd_en;         // read start store
        logic       rd_first;      // read address 0, else walk index + 1
        logic       prev_load;     // latch read data as start of current channel
        logic       out_load;      // load output register
        logic [1:0] out_status;
        logic       out_last;
        logic       stats_wr;      // update min/max of walked channel
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_full_pin_slot;   // pin of expected slot is high
        logic last_pin_high;      // pin of final slot is high
        logic out_free;           // output register can take a result
    } stat_t;

endpackage

FILE: design/rcpw_datapath.sv
// ----------------------------------------------------------------------------
// rcpw_datapath
// Sample register, start time store, width arithmetic, min/max stores and
// output register.
// ----------------------------------------------------------------------------
module rcpw_datapath #(
    parameter int CHANNELS = 8,
    parameter int TW       = 16,
    parameter int IDX_W    = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    input  logic                    sample_ready,
    input  rcpw_pkg::sample_t       sample,
    output logic                    result_valid,
    input  logic                    result_ready,
    output rcpw_pkg::result_t       result,
    input  rcpw_pkg::cmd_t          cmd,
    input  logic [IDX_W-1:0]        slot,
    input  logic [IDX_W-1:0]        walk_idx,
    output rcpw_pkg::stat_t         stat
);

    rcpw_pkg::sample_t  smp_reg;
    logic [TW-1:0]      start_mem [CHANNELS];
    logic [TW-1:0]      rd_data_reg;
    logic [TW-1:0]      prev_reg;
    logic [TW-1:0]      frame_end_reg;
    logic [TW-1:0]      min_reg [CHANNELS];
    logic [TW-1:0]      max_reg [CHANNELS];
    logic               out_valid_reg;
    rcpw_pkg::result_t  out_reg;
    rcpw_pkg::result_t  out_next;

    logic [TW-1:0]      now;
    logic [TW-1:0]      end_t;
    logic [TW-1:0]      width;
    logic [TW-1:0]      cur_min;
    logic [TW-1:0]      cur_max;
    logic [TW-1:0]      new_min;
    logic [TW-1:0]      new_max;
    logic [IDX_W-1:0]   rd_addr;
    logic               slot_pin;
    logic               last_pin;

    assign now = TW'(smp_reg.timer_value);

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            smp_reg <= sample;
        end
    end

    // slots at 8 and above have no pin and read low
    always_comb
    begin
        slot_pin = 1'b0;
        last_pin = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (k < CHANNELS)
            begin
                if (int'(slot) == k)
                begin
                    slot_pin = smp_reg.pin_levels[k];
                end
                if (k == CHANNELS - 1)
                begin
                    last_pin = smp_reg.pin_levels[k];
                end
            end
        end
    end

    assign stat.in_full_pin_slot = slot_pin;
    assign stat.last_pin_high    = last_pin;
    assign stat.out_free         = !out_valid_reg || result_ready;

    // start time store: one write port, one registered read port
    assign rd_addr = cmd.rd_first ? '0 : IDX_W'(walk_idx + 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.start_wr)
        begin
            start_mem[slot] <= now;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= start_mem[rd_addr];
        end
        if (cmd.prev_load)
        begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.frame_end_wr)
        begin
            frame_end_reg <= now;
        end
    end

    // the last channel ends at the frame end, the others at the next start
    assign end_t   = cmd.out_last ? frame_end_reg : rd_data_reg;
    assign width   = end_t - prev_reg;
    assign cur_min = min_reg[walk_idx];
    assign cur_max = max_reg[walk_idx];
    assign new_min = (width < cur_min || cur_min == '0) ? width : cur_min;
    assign new_max = (width > cur_max || cur_max == '0) ? width : cur_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                min_reg[k] <= '0;
                max_reg[k] <= '0;
            end
        end
        else if (cmd.stats_wr)
        begin
            min_reg[walk_idx] <= new_min;
            max_reg[walk_idx] <= new_max;
        end
    end

    always_comb
    begin
        out_next        = '0;
        out_next.status = cmd.out_status;
        out_next.last   = cmd.out_last;
        case (cmd.out_status)
            rcpw_pkg::ST_START:
            begin
                out_next.channel = 3'(slot);
            end
            rcpw_pkg::ST_REPORT:
            begin
                out_next.channel     = 3'(walk_idx);
                out_next.pulse_width = 16'(width);
                out_next.min_width   = 16'(new_min);
                out_next.max_width   = 16'(new_max);
            end
            default:
            begin
                out_next.channel = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: design/rcpw_ctrl.sv
// ----------------------------------------------------------------------------
// rcpw_ctrl
// Slot walk and frame report sequencer.
// ----------------------------------------------------------------------------
module rcpw_ctrl #(
    parameter int CHANNELS = 8,
    parameter int IDX_W    = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  rcpw_pkg::stat_t     stat,
    output rcpw_pkg::cmd_t      cmd,
    output logic [IDX_W-1:0]    slot,
    output logic [IDX_W-1:0]    walk_idx
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CALC  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    logic             waiting_reg, waiting_next;
    logic             in_full_reg, in_full_next;
    logic             accept;

    assign sample_ready = !in_full_reg || cmd.in_release;
    assign accept       = sample_valid && sample_ready;
    assign slot         = slot_reg;
    assign walk_idx     = walk_reg;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        slot_next    = slot_reg;
        walk_next    = walk_reg;
        waiting_next = waiting_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_full_reg && stat.out_free)
                begin
                    cmd.in_release = 1'b1;
                    cmd.out_last   = 1'b1;
                    if (waiting_reg)
                    begin
                        if (stat.last_pin_high)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = rcpw_pkg::ST_NONE;
                        end
                        else
                        begin
                            // falling edge of the final slot closes the frame
                            cmd.frame_end_wr = 1'b1;
                            waiting_next     = 1'b0;
                            slot_next        = '0;
                            state_next       = S_FETCH;
                        end
                    end
                    else if (stat.in_full_pin_slot)
                    begin
                        cmd.start_wr   = 1'b1;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = rcpw_pkg::ST_START;
                        if (slot_reg == LAST_IDX)
                        begin
                            waiting_next = 1'b1;
                        end
                        else
                        begin
                            slot_next = IDX_W'(slot_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = rcpw_pkg::ST_NONE;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = 1'b1;
                walk_next    = '0;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.prev_load = 1'b1;
                cmd.rd_en     = (walk_reg != LAST_IDX);
                state_next    = S_CALC;
            end
            S_CALC:
            begin
                cmd.out_last   = (walk_reg == LAST_IDX);
                cmd.out_status = rcpw_pkg::ST_REPORT;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.stats_wr = 1'b1;
                    if (walk_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        walk_next  = IDX_W'(walk_reg + 1'b1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (cmd.in_release)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            walk_reg    <= '0;
            waiting_reg <= 1'b0;
            in_full_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            walk_reg    <= walk_next;
            waiting_reg <= waiting_next;
            in_full_reg <= in_full_next;
        end
    end

endmodule

FILE: design/rc_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture
// Width capture for servo pulses that fire in a fixed slot order, with
// per-channel running minimum and maximum.
// ----------------------------------------------------------------------------
//  port group     dir  handshake                    payload
//  sample         in   sample_valid / sample_ready  rcpw_pkg::sample_t
//  result         out  result_valid / result_ready  rcpw_pkg::result_t
//
//  A sample held in the input register that gives one result is resolved once
//  the sequencer is idle and the output register is free; the input register
//  refills in the same cycle, so one sample per cycle while results are taken.
//  A frame-closing sample is handled in a closing step, a fetch of the first
//  start time, then a read step and a calc step per channel because of the
//  registered read of the start time store.
//  Reset clears the walk state and the min/max stores; start times are not
//  cleared. A stalled result holds the output register and the walk.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture #(
    parameter int CHANNELS   = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  rcpw_pkg::sample_t  sample,
    output logic               result_valid,
    input  logic               result_ready,
    output rcpw_pkg::result_t  result
);

    // widths wrap at the timer width; results carry the low 16 bits
    localparam int TW    = TIMER_BITS;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    rcpw_pkg::cmd_t   cmd;
    rcpw_pkg::stat_t  stat;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] walk_idx;

    rcpw_ctrl #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .stat         (stat),
        .cmd          (cmd),
        .slot         (slot),
        .walk_idx     (walk_idx)
    );

    rcpw_datapath #(
        .CHANNELS (CHANNELS),
        .TW       (TW),
        .IDX_W    (IDX_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cmd          (cmd),
        .slot         (slot),
        .walk_idx     (walk_idx),
        .stat         (stat)
    );

endmodule

FILE: design/rcpw_checker.sv
// ----------------------------------------------------------------------------
// rcpw_checker
// Port-level checks on the result channel of the pulse width capture block.
// ----------------------------------------------------------------------------
`include "rc_pulse_width_capture_macros.svh"

module rcpw_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input rcpw_pkg::result_t  result
);

    `RCPW_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")

    `RCPW_ASSERT(a_report_bounds, result_valid && result.status == rcpw_pkg::ST_REPORT && result.pulse_width != 16'd0 |-> result.min_width <= result.pulse_width && result.pulse_width <= result.max_width, "width outside min/max")

    `RCPW_ASSERT(a_idle_clean, result_valid && result.status == rcpw_pkg::ST_NONE |-> result.last && result.channel == 3'd0 && result.pulse_width == 16'd0 && result.min_width == 16'd0 && result.max_width == 16'd0, "no-edge result not clean")

    `RCPW_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !result_valid, "result valid after reset")

endmodule

bind rc_pulse_width_capture rcpw_checker u_rcpw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

FILE: tb/sv/rc_pulse_width_capture_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_test
// Self-checking bench for the servo pulse width capture block. Poll samples
// go in over a valid/ready channel. A behavioral copy of the slot walk and the
// min/max statistics predicts every result, and each result is checked field
// by field in arrival order. Sender and receiver idle at random, and one long
// receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture_test;

    localparam int NUM_CH      = 8;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 4 * (1 + 2 * NUM_CH);

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_ready;
    rcpw_pkg::sample_t sample       = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    rcpw_pkg::result_t result;

    // idle mix, hold-off control
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_active    = 1'b0;
    event hold_trigger;

    // predicted block state
    logic [2:0]  walk_slot     = '0;
    logic        awaiting_fall = 1'b0;
    logic [15:0] slot_start [NUM_CH];
    logic [15:0] frame_end;
    logic [15:0] width_min [NUM_CH] = '{default: '0};
    logic [15:0] width_max [NUM_CH] = '{default: '0};

    rcpw_pkg::result_t expected_results [$];
    logic [15:0]       timer_now = '0;

    int error_count    = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int starts_seen    = 0;
    int reports_seen   = 0;

    rc_pulse_width_capture #(
        .CHANNELS   (NUM_CH),
        .TIMER_BITS (16)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Walk / frame-close behavior; pushes the results one sample causes.
    task automatic predict_capture(input rcpw_pkg::sample_t s);
        rcpw_pkg::result_t r;
        logic [15:0]       stop;
        logic [15:0]       w;
        int                i;
        r        = '0;
        r.status = rcpw_pkg::ST_NONE;
        r.last   = 1'b1;
        if (awaiting_fall && !s.pin_levels[NUM_CH-1])
        begin
            frame_end     = s.timer_value;
            awaiting_fall = 1'b0;
            walk_slot     = '0;
            for (i = 0; i < NUM_CH; i++)
            begin
                stop = (i == NUM_CH - 1) ? frame_end : slot_start[(i + 1) % NUM_CH];
                w    = stop - slot_start[i];
                // zero in a statistic means unset
                if (w < width_min[i] || width_min[i] == '0)
                    width_min[i] = w;
                if (w > width_max[i] || width_max[i] == '0)
                    width_max[i] = w;
                r.status      = rcpw_pkg::ST_REPORT;
                r.channel     = i[2:0];
                r.pulse_width = w;
                r.min_width   = width_min[i];
                r.max_width   = width_max[i];
                r.last        = (i == NUM_CH - 1);
                expected_results.push_back(r);
            end
        end
        else
        begin
            if (!awaiting_fall && s.pin_levels[walk_slot])
            begin
                slot_start[walk_slot] = s.timer_value;
                r.status  = rcpw_pkg::ST_START;
                r.channel = walk_slot;
                if (walk_slot == NUM_CH - 1)
                    awaiting_fall = 1'b1;
                else
                    walk_slot = walk_slot + 3'd1;
            end
            expected_results.push_back(r);
        end
    endtask

    task automatic send_sample(input logic [7:0] pins, input logic [15:0] ticks);
        rcpw_pkg::sample_t s;
        int                gap;
        s.pin_levels  = pins;
        s.timer_value = ticks;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_capture(s);
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    // One sample shaped around the current walk position, random content.
    task automatic send_walk_sample(input int hit_pct, input int noise_pct);
        logic [7:0]  pins;
        logic [15:0] step;
        case ($urandom_range(9))
            0:       step = '0;
            1:       step = 16'($urandom_range(65535));
            default: step = 16'($urandom_range(1, 2500));
        endcase
        timer_now = timer_now + step;
        pins      = 8'($urandom_range(255));
        if ($urandom_range(99) >= noise_pct)
        begin
            if (awaiting_fall)
                pins[NUM_CH-1] = ($urandom_range(99) < 50);
            else
                pins[walk_slot] = ($urandom_range(99) < hit_pct);
        end
        send_sample(pins, timer_now);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct   = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic check_result(input rcpw_pkg::result_t got);
        rcpw_pkg::result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %p", got));
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.status != want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.channel != want.channel)
                report_mismatch($sformatf("channel %0d, want %0d", got.channel, want.channel));
            if (got.pulse_width != want.pulse_width)
                report_mismatch($sformatf("ch%0d width %h, want %h",
                                          want.channel, got.pulse_width, want.pulse_width));
            if (got.min_width != want.min_width)
                report_mismatch($sformatf("ch%0d min %h, want %h",
                                          want.channel, got.min_width, want.min_width));
            if (got.max_width != want.max_width)
                report_mismatch($sformatf("ch%0d max %h, want %h",
                                          want.channel, got.max_width, want.max_width));
            if (got.last != want.last)
                report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
            if (want.status == rcpw_pkg::ST_START)
                starts_seen++;
            if (want.status == rcpw_pkg::ST_REPORT)
                reports_seen++;
        end
    endtask

    // result side: check every taken result, random stalls, long hold-off
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            check_result(result);
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_trigger);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // Edge values: empty/full pin masks, timer 0 and max, wrap inside a pulse,
    // zero-width pulse, ignored pins while waiting for the last fall, and a
    // second frame that moves both min and max.
    task automatic test_directed_frames();
        send_sample(8'h00, 16'hFFFF);
        send_sample(8'hFE, 16'h0000);
        send_sample(8'h01, 16'hFFF0);
        send_sample(8'hFF, 16'h0010);
        send_sample(8'h04, 16'h0010);
        send_sample(8'h08, 16'h0100);
        send_sample(8'h10, 16'h0200);
        send_sample(8'h20, 16'h4000);
        send_sample(8'h40, 16'h8000);
        send_sample(8'h80, 16'hFFFF);
        send_sample(8'h80, 16'h0000);
        send_sample(8'hFF, 16'h1234);
        send_sample(8'h7F, 16'h0005);
        send_sample(8'hFF, 16'h0100);
        send_sample(8'hFF, 16'h0101);
        send_sample(8'hFF, 16'h0101);
        send_sample(8'hFF, 16'h9101);
        send_sample(8'hFF, 16'h9102);
        send_sample(8'hFF, 16'h9200);
        send_sample(8'hFF, 16'hA000);
        send_sample(8'hFF, 16'hA010);
        send_sample(8'h00, 16'hFFFF);
        timer_now = 16'hFFFF;
    endtask

    task automatic test_random_frames(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_walk_sample(70, 8);
    endtask

    // receiver holds off while whole frames keep coming in
    task automatic test_result_backpressure(input int count);
        int n;
        -> hold_trigger;
        for (n = 0; n < count; n++)
            send_walk_sample(100, 0);
    endtask

    task automatic test_random_noise(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_sample(8'($urandom_range(255)), 16'($urandom_range(65535)));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(22, 50);
        test_directed_frames();
        test_random_frames(140);

        set_idling(50, 22);
        test_random_frames(140);

        set_idling(0, 0);
        test_result_backpressure(50);
        test_random_noise(40);
        test_random_frames(80);

        sample_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d samples: %0d slot starts, %0d channel reports, %0d results.",
                 samples_sent, starts_seen, reports_seen, results_seen);
        $display("Three idle mixes plus a %0d-cycle result hold-off; %0d mismatches.",
                 HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #8000000;
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: rc_pulse_width_capture.f
+incdir+design
design/rcpw_pkg.sv
design/rcpw_datapath.sv
design/rcpw_ctrl.sv
design/rc_pulse_width_capture.sv
design/rcpw_checker.sv
tb/sv/rc_pulse_width_capture_test.sv
